// ===== src/npe_pkg.sv =====
`timescale 1ns / 1ps
// shared types for the next permutation engine
package npe_pkg;

    // status of one result item, passed from the sequencer to the output stage
    typedef struct packed {
        logic valid;
        logic last;
        logic wrapped;
        logic overflow;
    } t_emit;

endpackage

// ===== src/npe_store.sv =====
`timescale 1ns / 1ps
// element store: one write port, one read port with registered read data
module npe_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/npe_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer: load, pivot scan, successor scan, swap, suffix reversal and emission
module npe_ctrl #(
    parameter int MAX_LEN    = 64,
    parameter int ELEM_WIDTH = 16,
    parameter int AW         = $clog2(MAX_LEN)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [ELEM_WIDTH-1:0] i_value,
    input  logic                  i_last_in,
    output logic                  o_busy,
    output logic                  o_we,
    output logic [AW-1:0]         o_waddr,
    output logic [ELEM_WIDTH-1:0] o_wdata,
    output logic [AW-1:0]         o_raddr,
    input  logic [ELEM_WIDTH-1:0] i_rdata,
    output npe_pkg::t_emit        o_emit
);

    localparam int CW = $clog2(MAX_LEN + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_PIVA, S_PIV0, S_PIV, S_SUCC, S_SW1, S_SW2,
        S_RVA, S_RVB, S_RVC, S_RVD, S_EMIT
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [AW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_piv, n_piv;
    logic [AW-1:0]         r_lo, n_lo;
    logic [AW-1:0]         r_hi, n_hi;
    logic [ELEM_WIDTH-1:0] r_a, n_a;
    logic [ELEM_WIDTH-1:0] r_b, n_b;
    logic                  r_wrap, n_wrap;
    logic                  r_ovf, n_ovf;

    logic [CW-1:0]         w_cnt_m1;
    logic [AW-1:0]         w_last_idx;
    logic [ELEM_WIDTH-1:0] w_cmp_a, w_cmp_b;
    logic                  w_lt;

    assign w_cnt_m1   = r_cnt - CW'(1);
    assign w_last_idx = w_cnt_m1[AW-1:0];

    // the one shared signed comparator
    assign w_cmp_a = (r_state == S_SUCC) ? r_b : i_rdata;
    assign w_cmp_b = (r_state == S_SUCC) ? i_rdata : r_b;
    assign w_lt    = $signed(w_cmp_a) < $signed(w_cmp_b);

    assign o_busy = (r_state != S_LOAD);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_piv   = r_piv;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_a     = r_a;
        n_b     = r_b;
        n_wrap  = r_wrap;
        n_ovf   = r_ovf;
        o_we    = 1'b0;
        o_waddr = r_lo;
        o_wdata = i_rdata;
        o_raddr = r_idx;
        o_emit  = '0;
        case (r_state)
            S_LOAD: begin
                if (i_start) begin
                    if (r_cnt < CW'(MAX_LEN)) begin
                        o_we    = 1'b1;
                        o_waddr = r_cnt[AW-1:0];
                        o_wdata = i_value;
                        n_cnt   = r_cnt + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_in) begin
                        n_state = S_PIVA;
                    end
                end
            end
            S_PIVA: begin
                o_raddr = w_last_idx;
                n_idx   = w_last_idx;
                n_state = S_PIV0;
            end
            S_PIV0: begin
                if (r_idx == '0) begin
                    // single element: nothing to permute
                    n_wrap  = 1'b1;
                    n_piv   = '0;
                    n_lo    = '0;
                    n_hi    = '0;
                    n_state = S_RVA;
                end else begin
                    n_b     = i_rdata;
                    o_raddr = r_idx - AW'(1);
                    n_idx   = r_idx - AW'(1);
                    n_state = S_PIV;
                end
            end
            S_PIV: begin
                if (w_lt) begin
                    n_piv   = r_idx;
                    n_b     = i_rdata;
                    o_raddr = w_last_idx;
                    n_idx   = w_last_idx;
                    n_state = S_SUCC;
                end else if (r_idx == '0) begin
                    // greatest arrangement: reverse it all
                    n_wrap  = 1'b1;
                    n_piv   = '0;
                    n_lo    = '0;
                    n_hi    = w_last_idx;
                    n_state = S_RVA;
                end else begin
                    n_b     = i_rdata;
                    o_raddr = r_idx - AW'(1);
                    n_idx   = r_idx - AW'(1);
                end
            end
            S_SUCC: begin
                if (w_lt) begin
                    n_a     = i_rdata;
                    n_state = S_SW1;
                end else begin
                    o_raddr = r_idx - AW'(1);
                    n_idx   = r_idx - AW'(1);
                end
            end
            S_SW1: begin
                o_we    = 1'b1;
                o_waddr = r_piv;
                o_wdata = r_a;
                n_state = S_SW2;
            end
            S_SW2: begin
                o_we    = 1'b1;
                o_waddr = r_idx;
                o_wdata = r_b;
                n_lo    = r_piv + AW'(1);
                n_hi    = w_last_idx;
                n_state = S_RVA;
            end
            S_RVA: begin
                if (r_lo < r_hi) begin
                    o_raddr = r_lo;
                    n_state = S_RVB;
                end else begin
                    o_raddr = '0;
                    n_idx   = '0;
                    n_state = S_EMIT;
                end
            end
            S_RVB: begin
                n_a     = i_rdata;
                o_raddr = r_hi;
                n_state = S_RVC;
            end
            S_RVC: begin
                o_we    = 1'b1;
                o_waddr = r_lo;
                o_wdata = i_rdata;
                n_state = S_RVD;
            end
            S_RVD: begin
                o_we    = 1'b1;
                o_waddr = r_hi;
                o_wdata = r_a;
                n_lo    = r_lo + AW'(1);
                n_hi    = r_hi - AW'(1);
                n_state = S_RVA;
            end
            S_EMIT: begin
                o_emit.valid    = 1'b1;
                o_emit.last     = (r_idx == w_last_idx);
                o_emit.wrapped  = r_wrap;
                o_emit.overflow = r_ovf;
                if (r_idx == w_last_idx) begin
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                    n_wrap  = 1'b0;
                    n_state = S_LOAD;
                end else begin
                    o_raddr = r_idx + AW'(1);
                    n_idx   = r_idx + AW'(1);
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_wrap  <= 1'b0;
            r_ovf   <= 1'b0;
            r_piv   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_wrap  <= n_wrap;
            r_ovf   <= n_ovf;
            r_piv   <= n_piv;
            r_idx   <= n_idx;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_a     <= n_a;
            r_b     <= n_b;
        end
    end

endmodule

// ===== src/next_permutation_engine_core.sv =====
`timescale 1ns / 1ps
// top level of the next permutation engine
//
// Elements are loaded one item per cycle while busy is low (start high takes
// an item); up to MAX_LEN are stored and any more are dropped, with overflow
// raised on every result of that sequence. The item with last_in set ends the
// sequence: busy rises and the engine forms the next lexicographic arrangement
// in place in an element memory with one write and one read port, using one
// signed comparator under a small sequencer. After the last item it scans
// from the end for the pivot; if one is found it scans from the end for its
// successor and swaps the two, then reverses the suffix after the pivot
// (the whole sequence when there is none) one pair at a time and emits the
// arrangement, all through the one memory read port. Results leave on
// consecutive cycles, each shown for exactly one cycle with o_result_valid
// high; the receiver cannot hold them off. busy falls as the final result
// is shown, and a new sequence may start at once.
module next_permutation_engine_core #(
    parameter int MAX_LEN    = 64,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ELEM_WIDTH-1:0] i_value,
    input  logic                  i_last_in,
    output logic                  o_result_valid,
    output logic [ELEM_WIDTH-1:0] o_result_value,
    output logic                  o_last_out,
    output logic                  o_wrapped,
    output logic                  o_overflow
);

    localparam int AW = $clog2(MAX_LEN);

    // memory port signals
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [ELEM_WIDTH-1:0] w_wdata;
    logic [AW-1:0]         w_raddr;
    logic [ELEM_WIDTH-1:0] w_rdata;
    npe_pkg::t_emit        w_emit;

    // output stage
    npe_pkg::t_emit        r_out;
    logic [ELEM_WIDTH-1:0] r_value;

    npe_store #(
        .DEPTH (MAX_LEN),
        .WIDTH (ELEM_WIDTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    npe_ctrl #(
        .MAX_LEN    (MAX_LEN),
        .ELEM_WIDTH (ELEM_WIDTH),
        .AW         (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_value   (i_value),
        .i_last_in (i_last_in),
        .o_busy    (busy),
        .o_we      (w_we),
        .o_waddr   (w_waddr),
        .o_wdata   (w_wdata),
        .o_raddr   (w_raddr),
        .i_rdata   (w_rdata),
        .o_emit    (w_emit)
    );

    // register the item being emitted together with its memory data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else begin
            r_out <= w_emit;
        end
        r_value <= w_rdata;
    end

    assign o_result_valid = r_out.valid;
    assign o_result_value = r_value;
    assign o_last_out     = r_out.last;
    assign o_wrapped      = r_out.wrapped;
    assign o_overflow     = r_out.overflow;

endmodule

// ===== src/npe_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the next permutation engine, bound to the top level
module npe_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_last_in,
    input logic o_result_valid,
    input logic o_last_out,
    input logic o_wrapped,
    input logic o_overflow
);

    // a last item always starts processing
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_last_in |=> busy)
        else $error("busy not raised after last item");

    // other items keep the engine loading
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_last_in |=> !busy)
        else $error("busy raised on a non-last item");

    // results other than the final one come while busy
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_last_out |-> busy)
        else $error("result shown while idle");

    // results of one sequence are back to back with steady flags
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_last_out |=>
            o_result_valid && $stable(o_wrapped) && $stable(o_overflow))
        else $error("gap or flag change within a result burst");

    // the final result closes the burst
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_last_out |=> !o_result_valid)
        else $error("result after the final one");

endmodule

bind next_permutation_engine_core npe_checker u_npe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_last_in      (i_last_in),
    .o_result_valid (o_result_valid),
    .o_last_out     (o_last_out),
    .o_wrapped      (o_wrapped),
    .o_overflow     (o_overflow)
);
